// ===== rtl/gep_pkg.sv =====
// Package for the guide-error to pulse converter: widths, event codes,
// register indexes and the structs passed between the top level and the axis unit.
// No dependencies.
package gep_pkg;

   localparam int unsigned ERR_W   = 24;
   localparam int unsigned MAG_W   = 24;
   localparam int unsigned RATE_W  = 24;
   localparam int unsigned GAIN_W  = 12;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned CSR_W   = 24;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned PROD_W  = 48;
   localparam int unsigned NUM_W   = 37;
   localparam int unsigned ACC_W   = 50;
   localparam int unsigned SROOT_W = 24;
   localparam int unsigned SREM_W  = 26;
   localparam int unsigned CNT_W   = 6;

   localparam int unsigned PULSE_STEPS = NUM_W;
   localparam int unsigned DIV_STEPS   = ACC_W;
   localparam int unsigned SQRT_STEPS  = SROOT_W;

   localparam logic [3:0] DIV_TEN = 4'd10;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 12'd256;

   localparam logic [1:0] FUNC_STEP  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RA_RATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEC_RATE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AGGRESSION = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_RA    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_DEC   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE  = 3'd7;

   typedef struct packed {
      logic              calibrated;
      logic [GAIN_W-1:0] aggression;
      logic              invert;
      logic [MS_W-1:0]   min_pulse;
      logic [MS_W-1:0]   max_pulse;
   } gep_axis_cfg_type;

   typedef struct packed {
      logic [MS_W-1:0]  pulse_ms;
      logic             dir;
      logic [MAG_W-1:0] rms;
   } gep_axis_res_type;

endpackage

// ===== rtl/gep_if.sv =====
// Channel interfaces of the guide-error to pulse converter: request and response.
// Depends on gep_pkg.
interface gep_req_if import gep_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic signed [ERR_W-1:0] ra_error;
   logic signed [ERR_W-1:0] dec_error;
   logic              mount_connected;

   modport source (output valid, func, ra_error, dec_error, mount_connected, input ready);
   modport sink (input valid, func, ra_error, dec_error, mount_connected, output ready);
endinterface

interface gep_rsp_if import gep_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              applied;
   logic [MS_W-1:0]   ra_pulse_ms;
   logic              ra_west;
   logic [MS_W-1:0]   dec_pulse_ms;
   logic              dec_south;
   logic [MAG_W-1:0]  rms_ra;
   logic [MAG_W-1:0]  rms_dec;

   modport source (output valid, applied, ra_pulse_ms, ra_west, dec_pulse_ms, dec_south,
                   rms_ra, rms_dec, input ready);
   modport sink (input valid, applied, ra_pulse_ms, ra_west, dec_pulse_ms, dec_south,
                 rms_ra, rms_dec, output ready);
endinterface

// ===== rtl/gep_axis.sv =====
// One guide axis: pulse length by bit-serial division and smoothed RMS by
// a bit-serial divide by ten followed by a bit-serial square root.
// Depends on gep_pkg.
module gep_axis import gep_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MAG_W-1:0]    mag,
   input  logic                pos,
   input  logic [RATE_W-1:0]   rate,
   input  logic [MAG_W-1:0]    r_old,
   input  logic                first,
   input  gep_axis_cfg_type    cfg,
   output logic                done,
   output gep_axis_res_type    res
);

   typedef enum logic [7:0] {
      AX_IDLE = 8'b0000_0001,
      AX_MULA = 8'b0000_0010,
      AX_MULB = 8'b0000_0100,
      AX_MULC = 8'b0000_1000,
      AX_SUM  = 8'b0001_0000,
      AX_DIV  = 8'b0010_0000,
      AX_SQRT = 8'b0100_0000,
      AX_DONE = 8'b1000_0000
   } ax_state_type;

   ax_state_type        state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                pos_ff, pos_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [MAG_W-1:0]    r_ff, r_in;
   logic                first_ff, first_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [RATE_W:0]     drem_ff, drem_in;
   logic [MS_W-1:0]     q_ff, q_in;
   logic                ovf_ff, ovf_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [3:0]          rem10_ff, rem10_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [SROOT_W-1:0]  root_ff, root_in;

   logic [GAIN_W-1:0]   gain_eff;
   logic [MAG_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]   mul_p;
   logic [RATE_W+1:0]   d_rem2;
   logic [RATE_W:0]     d_div;
   logic                d_ge;
   logic [4:0]          t_rem2;
   logic                t_ge;
   logic [SREM_W+1:0]   s_rem2, s_trial;
   logic                s_ge;
   logic [MS_W-1:0]     ceiling;
   logic [MS_W-1:0]     ms;

   assign gain_eff = (cfg.aggression == '0) ? GAIN_UNITY : cfg.aggression;

   always_comb begin
      mul_a = mag_ff;
      mul_b = MAG_W'(gain_eff);
      case (state_ff)
         AX_MULB: begin
            mul_a = r_ff;
            mul_b = r_ff;
         end
         AX_MULC: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign d_div  = {rate_ff, 1'b0};
   assign d_rem2 = {drem_ff, num_ff[NUM_W-1]};
   assign d_ge   = d_rem2 >= {1'b0, d_div};

   assign t_rem2 = {rem10_ff, acc_ff[ACC_W-1]};
   assign t_ge   = t_rem2 >= {1'b0, DIV_TEN};

   assign s_rem2  = {srem_ff, acc_ff[2*SROOT_W-1 -: 2]};
   assign s_trial = {2'b00, root_ff, 2'b01};
   assign s_ge    = s_rem2 >= s_trial;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      pos_in   = pos_ff;
      rate_in  = rate_ff;
      r_in     = r_ff;
      first_in = first_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      drem_in  = drem_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      acc_in   = acc_ff;
      rem10_in = rem10_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      case (state_ff)
         AX_IDLE: begin
            if (start) begin
               mag_in   = mag;
               pos_in   = pos;
               rate_in  = rate;
               r_in     = r_old;
               first_in = first;
               state_in = AX_MULA;
            end
         end
         AX_MULA: begin
            prod_in  = mul_p;
            state_in = AX_MULB;
         end
         AX_MULB: begin
            num_in   = {prod_ff[NUM_W-2:0], 1'b0} + NUM_W'(rate_ff);
            prod_in  = mul_p;
            state_in = AX_MULC;
         end
         AX_MULC: begin
            acc_in   = {prod_ff[ACC_W-4:0], 3'b000} + ACC_W'(prod_ff[ACC_W-4:0]);
            prod_in  = mul_p;
            state_in = AX_SUM;
         end
         AX_SUM: begin
            acc_in   = acc_ff + ACC_W'(prod_ff[ACC_W-4:0]);
            cnt_in   = '0;
            drem_in  = '0;
            q_in     = '0;
            ovf_in   = 1'b0;
            rem10_in = '0;
            state_in = AX_DIV;
         end
         AX_DIV: begin
            if (cnt_ff < CNT_W'(PULSE_STEPS)) begin
               num_in  = {num_ff[NUM_W-2:0], 1'b0};
               drem_in = d_ge ? (RATE_W+1)'(d_rem2 - {1'b0, d_div})
                              : (RATE_W+1)'(d_rem2);
               q_in    = {q_ff[MS_W-2:0], d_ge};
               ovf_in  = ovf_ff | q_ff[MS_W-1];
            end
            rem10_in = t_ge ? 4'(t_rem2 - {1'b0, DIV_TEN}) : t_rem2[3:0];
            acc_in   = {acc_ff[ACC_W-2:0], t_ge};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               srem_in  = '0;
               root_in  = '0;
               state_in = AX_SQRT;
            end
         end
         AX_SQRT: begin
            srem_in = s_ge ? SREM_W'(s_rem2 - s_trial) : SREM_W'(s_rem2);
            root_in = {root_ff[SROOT_W-2:0], s_ge};
            acc_in  = {acc_ff[ACC_W-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = AX_DONE;
            end
         end
         AX_DONE: begin
            state_in = AX_IDLE;
         end
         default: begin
            state_in = AX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      mag_ff   <= mag_in;
      pos_ff   <= pos_in;
      rate_ff  <= rate_in;
      r_ff     <= r_in;
      first_ff <= first_in;
      prod_ff  <= prod_in;
      num_ff   <= num_in;
      drem_ff  <= drem_in;
      q_ff     <= q_in;
      ovf_ff   <= ovf_in;
      acc_ff   <= acc_in;
      rem10_ff <= rem10_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
   end

   // An overflowed quotient is above any ceiling, so it clamps.
   always_comb begin
      ceiling = (cfg.max_pulse > cfg.min_pulse) ? cfg.max_pulse : cfg.min_pulse;
      ms = '0;
      if (cfg.calibrated && (rate_ff != '0)) begin
         if (ovf_ff) begin
            ms = ceiling;
         end else if ((q_ff != '0) && (q_ff >= cfg.min_pulse)) begin
            ms = (q_ff > ceiling) ? ceiling : q_ff;
         end
      end
   end

   assign done         = state_ff == AX_DONE;
   assign res.pulse_ms = ms;
   assign res.dir      = (ms != '0) && (pos_ff != cfg.invert);
   assign res.rms      = first_ff ? mag_ff : root_ff;

endmodule

// ===== rtl/guide_error_to_pulse_with_rms_top.sv =====
// Channel     Dir  Payload                                              Transfer
// req_if      in   func, ra_error, dec_error, mount_connected           valid & ready
// rsp_if      out  applied, pulse lengths, directions, rms_ra, rms_dec  valid & ready
// csr_*       in   csr_index, csr_wdata                                 csr_we
//
// A guide step that is acted on runs, in each axis, through the multiply states MULA,
// MULB and MULC and a sum, a divide by ten and a square root, then a done state; the
// top level then enters its finish state and loads the output register once it is free.
// Any other event goes straight to the finish state and then loads the output register.
// Reset is synchronous and active high; it restores state, CSRs and RMS state, not output data or axis datapath.
// A new request is taken while the previous result waits in the output register.
// Top level of the guide-error to pulse converter; depends on gep_pkg, gep_if and gep_axis.
module guide_error_to_pulse_with_rms_top import gep_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   gep_req_if.sink              req_if,
   gep_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [RATE_W-1:0]  ra_rate_ff, dec_rate_ff;
   logic               calibrated_ff;
   logic [GAIN_W-1:0]  aggression_ff;
   logic               flip_ra_ff, flip_dec_ff;
   logic [MS_W-1:0]    min_pulse_ff, max_pulse_ff;
   logic               guiding_ff, guiding_in;
   logic               rms_started_ff;
   logic [MAG_W-1:0]   rms_ra_ff, rms_dec_ff;
   logic               applied_ff, applied_in;

   logic               rsp_valid_ff;
   logic               out_applied_ff;
   logic [MS_W-1:0]    out_ra_ms_ff, out_dec_ms_ff;
   logic               out_west_ff, out_south_ff;
   logic [MAG_W-1:0]   out_rms_ra_ff, out_rms_dec_ff;

   logic               transfer;
   logic               step_ok;
   logic               load;
   logic [MAG_W-1:0]   ra_mag, dec_mag;
   logic               ra_pos, dec_pos;
   gep_axis_cfg_type   ra_cfg, dec_cfg;
   gep_axis_res_type   ra_res, dec_res;
   logic               ra_done, dec_done;

   assign req_if.ready = state_ff == ST_IDLE;
   assign transfer     = req_if.valid && req_if.ready;
   assign step_ok      = (req_if.func == FUNC_STEP) && guiding_ff && req_if.mount_connected;
   assign load         = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_if.ready);

   assign ra_mag  = req_if.ra_error[ERR_W-1] ? MAG_W'(-req_if.ra_error)
                                             : MAG_W'(req_if.ra_error);
   assign dec_mag = req_if.dec_error[ERR_W-1] ? MAG_W'(-req_if.dec_error)
                                              : MAG_W'(req_if.dec_error);
   assign ra_pos  = !req_if.ra_error[ERR_W-1] && (req_if.ra_error != '0);
   assign dec_pos = !req_if.dec_error[ERR_W-1] && (req_if.dec_error != '0);

   assign ra_cfg  = '{calibrated: calibrated_ff, aggression: aggression_ff,
                      invert: flip_ra_ff, min_pulse: min_pulse_ff, max_pulse: max_pulse_ff};
   assign dec_cfg = '{calibrated: calibrated_ff, aggression: aggression_ff,
                      invert: flip_dec_ff, min_pulse: min_pulse_ff, max_pulse: max_pulse_ff};

   gep_axis u_ra_axis (
      .clock (clock),
      .reset (reset),
      .start (transfer && step_ok),
      .mag   (ra_mag),
      .pos   (ra_pos),
      .rate  (ra_rate_ff),
      .r_old (rms_ra_ff),
      .first (!rms_started_ff),
      .cfg   (ra_cfg),
      .done  (ra_done),
      .res   (ra_res)
   );

   gep_axis u_dec_axis (
      .clock (clock),
      .reset (reset),
      .start (transfer && step_ok),
      .mag   (dec_mag),
      .pos   (dec_pos),
      .rate  (dec_rate_ff),
      .r_old (rms_dec_ff),
      .first (!rms_started_ff),
      .cfg   (dec_cfg),
      .done  (dec_done),
      .res   (dec_res)
   );

   always_comb begin
      state_in   = state_ff;
      guiding_in = guiding_ff;
      applied_in = applied_ff;
      case (state_ff)
         ST_IDLE: begin
            if (transfer) begin
               applied_in = step_ok;
               state_in   = step_ok ? ST_RUN : ST_FIN;
               if (req_if.func == FUNC_START) begin
                  guiding_in = 1'b1;
               end else if (req_if.func == FUNC_STOP) begin
                  guiding_in = 1'b0;
               end
            end
         end
         ST_RUN: begin
            if (ra_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         guiding_ff     <= 1'b0;
         applied_ff     <= 1'b0;
         rms_started_ff <= 1'b0;
         rms_ra_ff      <= '0;
         rms_dec_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         ra_rate_ff     <= '0;
         dec_rate_ff    <= '0;
         calibrated_ff  <= 1'b0;
         aggression_ff  <= GAIN_UNITY;
         flip_ra_ff     <= 1'b0;
         flip_dec_ff    <= 1'b0;
         min_pulse_ff   <= MS_W'(1);
         max_pulse_ff   <= MS_W'(5000);
      end else begin
         state_ff   <= state_in;
         guiding_ff <= guiding_in;
         applied_ff <= applied_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load && applied_ff) begin
            rms_started_ff <= 1'b1;
            rms_ra_ff      <= ra_res.rms;
            rms_dec_ff     <= dec_res.rms;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_RA_RATE:    ra_rate_ff    <= csr_wdata[RATE_W-1:0];
               CSR_DEC_RATE:   dec_rate_ff   <= csr_wdata[RATE_W-1:0];
               CSR_CALIBRATED: calibrated_ff <= csr_wdata[0];
               CSR_AGGRESSION: aggression_ff <= csr_wdata[GAIN_W-1:0];
               CSR_FLIP_RA:    flip_ra_ff    <= csr_wdata[0];
               CSR_FLIP_DEC:   flip_dec_ff   <= csr_wdata[0];
               CSR_MIN_PULSE:  min_pulse_ff  <= csr_wdata[MS_W-1:0];
               CSR_MAX_PULSE:  max_pulse_ff  <= csr_wdata[MS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_applied_ff <= applied_ff;
         out_ra_ms_ff   <= applied_ff ? ra_res.pulse_ms : '0;
         out_west_ff    <= applied_ff && ra_res.dir;
         out_dec_ms_ff  <= applied_ff ? dec_res.pulse_ms : '0;
         out_south_ff   <= applied_ff && dec_res.dir;
         out_rms_ra_ff  <= applied_ff ? ra_res.rms : rms_ra_ff;
         out_rms_dec_ff <= applied_ff ? dec_res.rms : rms_dec_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.applied      = out_applied_ff;
   assign rsp_if.ra_pulse_ms  = out_ra_ms_ff;
   assign rsp_if.ra_west      = out_west_ff;
   assign rsp_if.dec_pulse_ms = out_dec_ms_ff;
   assign rsp_if.dec_south    = out_south_ff;
   assign rsp_if.rms_ra       = out_rms_ra_ff;
   assign rsp_if.rms_dec      = out_rms_dec_ff;

   // The two axis units run in lockstep.
   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      ra_done == dec_done)
      else $error("axis units out of step");

   // An axis unit only finishes while the top level waits for it.
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      ra_done |-> state_ff == ST_RUN)
      else $error("axis finished outside the run state");

   // Every acted-on step leaves the RMS state started.
   a_applied_started: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.applied) |-> rms_started_ff)
      else $error("applied result without RMS state");

   // A result that was not acted on carries no pulses.
   a_idle_no_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.applied) |->
         (rsp_if.ra_pulse_ms == '0 && rsp_if.dec_pulse_ms == '0 &&
          !rsp_if.ra_west && !rsp_if.dec_south))
      else $error("pulse on a result that was not acted on");

endmodule
